FILE: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and types of the rational arithmetic unit: default operand
// width, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_EQ  = 3'd4;
	localparam logic [2:0] OP_LT  = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_COMB,
		ST_PREP,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

endpackage

FILE: hdl/rau_in_if.sv
// ----------------------------------------------------------------------------
// rau_in_if
// Request channel: operation code and two fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rau_in_if
	import rau_pkg::*;
#(
	parameter int W = OPERAND_WIDTH_DEF
) ();
	logic                valid;
	logic                ready;
	logic [2:0]          operation;
	logic signed [W-1:0] left_num;
	logic [W-2:0]        left_den;
	logic signed [W-1:0] right_num;
	logic [W-2:0]        right_den;

	modport source (
		output valid, operation, left_num, left_den, right_num, right_den,
		input  ready
	);

	modport sink (
		input  valid, operation, left_num, left_den, right_num, right_den,
		output ready
	);
endinterface

FILE: hdl/rau_out_if.sv
// ----------------------------------------------------------------------------
// rau_out_if
// Response channel: reduced fraction and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rau_out_if
	import rau_pkg::*;
#(
	parameter int W = OPERAND_WIDTH_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic signed [2*W-1:0] result_num;
	logic [2*W-2:0]        result_den;
	logic                  compare_true;
	logic                  divide_by_zero;

	modport source (
		output valid, result_num, result_den, compare_true, divide_by_zero,
		input  ready
	);

	modport sink (
		input  valid, result_num, result_den, compare_true, divide_by_zero,
		output ready
	);
endinterface

FILE: hdl/rational_arithmetic_unit.sv
// Sequence: compare and unused codes go from the combine state to done, a zero
// numerator skips the gcd and the divisions, other arithmetic runs binary gcd steps.
// Throughput: one beat at a time; the next request is taken once the sequencer
// is back in idle, while the previous result may still wait in the output register.
// The time is set by the shared subtractor: gcd steps plus two restoring divisions.
// Reset: arst_n asynchronous, active low; clears sequencer and output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational add, subtract, multiply, divide and compare on signed fractions,
// with gcd reduction through one shared multiplier and one shared subtractor.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rau_in_if.sink    request,
	rau_out_if.source response
);

	localparam int W    = OPERAND_WIDTH;
	localparam int NW   = 2 * W;        // product / numerator width
	localparam int MW   = 2 * W - 1;    // magnitude width
	localparam int K_W  = $clog2(MW);
	localparam int CNT_W = $clog2(MW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MW - 1);

	state_t state_q, state_d;

	// latched request
	logic [2:0]          op_q;
	logic signed [W-1:0] ln_q, rn_q;
	logic [W-2:0]        ld_q, rd_q;

	// products and sum
	logic signed [NW-1:0] xl_q, xr_q, den_q;

	// reduction datapath
	logic [MW-1:0]    a_q, b_q, g_q, nmag_q, dmag_q;
	logic [K_W-1:0]   k_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q, plain_q, cmp_q, dz_q;

	// output register
	logic                  out_valid_q;
	logic signed [NW-1:0]  out_num_q;
	logic [MW-1:0]         out_den_q;
	logic                  out_cmp_q, out_dz_q;

	logic is_arith;
	logic out_free;
	assign is_arith = (op_q == OP_ADD) || (op_q == OP_SUB) ||
		(op_q == OP_MUL) || (op_q == OP_DIV);
	assign out_free = !out_valid_q || response.ready;

	// shared multiplier
	logic signed [W:0]      mul_a, mul_b;
	logic signed [2*W+1:0]  prod;

	always_comb begin
		mul_a = {ln_q[W-1], ln_q};
		mul_b = $signed({2'b00, rd_q});
		unique case (state_q)
			ST_MUL0: begin
				mul_a = {ln_q[W-1], ln_q};
				mul_b = (op_q == OP_MUL) ? {rn_q[W-1], rn_q} : $signed({2'b00, rd_q});
			end
			ST_MUL1: begin
				mul_a = {rn_q[W-1], rn_q};
				mul_b = $signed({2'b00, ld_q});
			end
			ST_MUL2: begin
				mul_a = $signed({2'b00, ld_q});
				mul_b = (op_q == OP_DIV) ? {rn_q[W-1], rn_q} : $signed({2'b00, rd_q});
			end
			default: begin
			end
		endcase
	end
	assign prod = (2*W+2)'(mul_a) * (2*W+2)'(mul_b);

	// sum / difference of cross products; other codes pass the left product
	logic signed [NW-1:0] comb_n;
	always_comb begin
		priority case (op_q)
			OP_ADD:  comb_n = xl_q + xr_q;
			OP_SUB:  comb_n = xl_q - xr_q;
			default: comb_n = xl_q;
		endcase
	end

	// magnitudes and sign ahead of the reduction
	logic signed [NW-1:0] n_neg, d_neg;
	logic [MW-1:0]        n_abs, d_abs;
	logic                 den_zero, num_zero;
	assign n_neg    = -xl_q;
	assign d_neg    = -den_q;
	assign n_abs    = xl_q[NW-1] ? n_neg[MW-1:0] : xl_q[MW-1:0];
	assign d_abs    = den_q[NW-1] ? d_neg[MW-1:0] : den_q[MW-1:0];
	assign den_zero = (den_q == '0);
	assign num_zero = (xl_q == '0);

	// shared subtractor: gcd difference or restoring division trial
	logic [MW:0]   sub_x, sub_y, sub_r;
	logic          a_ge_b;
	logic          div_msb;
	assign a_ge_b  = (a_q >= b_q);
	assign div_msb = (state_q == ST_DIVN) ? nmag_q[MW-1] : dmag_q[MW-1];

	always_comb begin
		if (state_q == ST_GCD) begin
			sub_x = a_ge_b ? {1'b0, a_q} : {1'b0, b_q};
			sub_y = a_ge_b ? {1'b0, b_q} : {1'b0, a_q};
		end else begin
			sub_x = {a_q, div_msb};
			sub_y = {1'b0, g_q};
		end
	end
	assign sub_r = sub_x - sub_y;

	logic          q_bit;
	logic [MW-1:0] rem_next;
	assign q_bit    = !sub_r[MW];
	assign rem_next = q_bit ? sub_r[MW-1:0] : sub_x[MW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (request.valid) begin
				state_d = ST_MUL0;
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_COMB;
			ST_COMB: state_d = is_arith ? ST_PREP : ST_DONE;
			ST_PREP: state_d = num_zero ? ST_DONE : ST_GCD;
			ST_GCD: if (a_q == '0) begin
				state_d = ST_DIVN;
			end
			ST_DIVN: if (cnt_q == CNT_LAST) begin
				state_d = ST_DIVD;
			end
			ST_DIVD: if (cnt_q == CNT_LAST) begin
				state_d = ST_DONE;
			end
			ST_DONE: if (out_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and payload outputs
	always_comb begin
		request.ready           = (state_q == ST_IDLE);
		response.valid          = out_valid_q;
		response.result_num     = out_num_q;
		response.result_den     = out_den_q;
		response.compare_true   = out_cmp_q;
		response.divide_by_zero = out_dz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (request.valid) begin
				op_q <= request.operation;
				ln_q <= request.left_num;
				ld_q <= request.left_den;
				rn_q <= request.right_num;
				rd_q <= request.right_den;
			end
			ST_MUL0: xl_q  <= prod[NW-1:0];
			ST_MUL1: xr_q  <= prod[NW-1:0];
			ST_MUL2: den_q <= prod[NW-1:0];
			ST_COMB: begin
				xl_q    <= comb_n;
				plain_q <= !is_arith;
				dz_q    <= (op_q == OP_DIV) && (rn_q == '0);
				priority case (op_q)
					OP_EQ:   cmp_q <= (xl_q == xr_q);
					OP_LT:   cmp_q <= (xl_q < xr_q);
					default: cmp_q <= 1'b0;
				endcase
			end
			ST_PREP: begin
				plain_q <= num_zero;
				// a zero denominator is taken as one
				neg_q   <= xl_q[NW-1] ^ (den_q[NW-1] && !den_zero);
				a_q     <= n_abs;
				b_q     <= den_zero ? MW'(1) : d_abs;
				nmag_q  <= n_abs;
				dmag_q  <= den_zero ? MW'(1) : d_abs;
				k_q     <= '0;
			end
			ST_GCD: begin
				// binary gcd, a ends at zero and leaves the remainder register clear
				priority if (a_q == '0) begin
					g_q   <= b_q << k_q;
					cnt_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + K_W'(1);
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_ge_b) begin
					a_q <= {1'b0, sub_r[MW-1:1]};
				end else begin
					b_q <= {1'b0, sub_r[MW-1:1]};
				end
			end
			ST_DIVN: begin
				a_q    <= rem_next;
				nmag_q <= {nmag_q[MW-2:0], q_bit};
				cnt_q  <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
			end
			ST_DIVD: begin
				a_q    <= rem_next;
				dmag_q <= {dmag_q[MW-2:0], q_bit};
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			ST_DONE: if (out_free) begin
				out_cmp_q <= cmp_q;
				out_dz_q  <= dz_q;
				if (plain_q) begin
					out_num_q <= '0;
					out_den_q <= MW'(1);
				end else begin
					out_num_q <= neg_q ? -$signed({1'b0, nmag_q}) : $signed({1'b0, nmag_q});
					out_den_q <= dmag_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |-> response.result_den != '0)
		else $error("result beat with zero denominator");

	a_cmp_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(response.valid && response.compare_true) |->
		(response.result_num == '0 && response.result_den == MW'(1)))
		else $error("compare beat carries a fraction");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |-> !(response.compare_true && response.divide_by_zero))
		else $error("compare and divide-by-zero flags both set");

	a_gcd_b_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GCD) |-> (b_q != '0))
		else $error("gcd operand reached zero");

	a_div_rem_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVD && $past(state_q) == ST_DIVN) |-> (a_q == '0))
		else $error("numerator not divisible by gcd");
`endif

endmodule

FILE: dv/rau_fraction_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_fraction_checker
// Watches the request and response channels of the rational arithmetic unit.
// Each request beat is turned into the expected reduced fraction or comparison
// flag. Response beats are checked in order against those expectations.
// ----------------------------------------------------------------------------
module rau_fraction_checker
	import rau_pkg::*;
#(
	parameter int W = OPERAND_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rau_in_if    request,
	rau_out_if   response,
	output int   fail_count,
	output int   pending_count
);

	typedef struct packed {
		logic [2:0]            operation;
		logic signed [2*W-1:0] num;
		logic [2*W-2:0]        den;
		logic                  compare_true;
		logic                  divide_by_zero;
	} fraction_t;

	fraction_t pending_fractions[$];
	int        errors = 0;

	function automatic fraction_t predict_fraction(
		input logic [2:0]          op,
		input logic signed [W-1:0] ln,
		input logic [W-2:0]        ld,
		input logic signed [W-1:0] rn,
		input logic [W-2:0]        rd
	);
		longint          left_n, left_d, right_n, right_d;
		longint          prod_l, prod_r, n, d;
		longint unsigned mn, md, a, b, t;
		logic            neg;
		fraction_t       f;
		left_n  = longint'(ln);
		left_d  = longint'(ld);
		right_n = longint'(rn);
		right_d = longint'(rd);
		prod_l  = left_n * right_d;
		prod_r  = right_n * left_d;
		n = 0;
		d = 1;
		f.operation      = op;
		f.compare_true   = 1'b0;
		f.divide_by_zero = 1'b0;
		case (op)
			OP_ADD: begin
				n = prod_l + prod_r;
				d = left_d * right_d;
			end
			OP_SUB: begin
				n = prod_l - prod_r;
				d = left_d * right_d;
			end
			OP_MUL: begin
				n = left_n * right_n;
				d = left_d * right_d;
			end
			OP_DIV: begin
				n = prod_l;
				d = left_d * right_n;
				f.divide_by_zero = (right_n == 0);
			end
			OP_EQ: f.compare_true = (prod_l == prod_r);
			OP_LT: f.compare_true = (prod_l < prod_r);
			default: ;
		endcase
		if (op <= OP_DIV) begin
			// a zero product denominator is taken as one
			if (d == 0)
				d = 1;
			if (n == 0) begin
				d = 1;
			end else begin
				neg = (n < 0) != (d < 0);
				mn  = (n < 0) ? -n : n;
				md  = (d < 0) ? -d : d;
				a   = mn;
				b   = md;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				mn = mn / a;
				md = md / a;
				n  = neg ? -longint'(mn) : longint'(mn);
				d  = longint'(md);
			end
		end
		f.num = n[2*W-1:0];
		f.den = d[2*W-2:0];
		return f;
	endfunction

	always @(posedge clk) begin : check_beats
		fraction_t oldest;
		if (arst_n) begin
			// retire first so a stray beat never matches the same-cycle request
			if (response.valid && response.ready) begin
				if (pending_fractions.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: response beat %0d/%0d cmp %0b dz %0b with nothing pending",
							$realtime, response.result_num, response.result_den,
							response.compare_true, response.divide_by_zero);
				end else begin
					oldest = pending_fractions.pop_front();
					if (response.result_num !== oldest.num ||
						response.result_den !== oldest.den ||
						response.compare_true !== oldest.compare_true ||
						response.divide_by_zero !== oldest.divide_by_zero) begin
						errors++;
						if (errors <= 10)
							$display("%0t: op %0d got %0d/%0d cmp %0b dz %0b, want %0d/%0d cmp %0b dz %0b",
								$realtime, oldest.operation,
								response.result_num, response.result_den,
								response.compare_true, response.divide_by_zero,
								oldest.num, oldest.den,
								oldest.compare_true, oldest.divide_by_zero);
					end
				end
			end
			if (request.valid && request.ready)
				pending_fractions.push_back(predict_fraction(request.operation,
					request.left_num, request.left_den,
					request.right_num, request.right_den));
		end
		fail_count    <= errors;
		pending_count <= pending_fractions.size();
	end

endmodule

FILE: dv/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives the rational arithmetic unit with directed corner fractions and then
// random requests under three pacing mixes; the checker module predicts every
// response and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int W                = OPERAND_WIDTH_DEF;
	localparam int NUM_MAX          = 2**(W-1) - 1;
	localparam int NUM_MIN          = -(2**(W-1));
	localparam int DEN_MAX          = 2**(W-1) - 1;
	localparam int RANDOM_PER_PHASE = 600;
	localparam int DRAIN_CYCLES     = 200;

	// codes the block leaves undefined
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	typedef logic signed [W-1:0] num_t;
	typedef logic [W-2:0]        den_t;

	// field-width copies of the extremes for directed beats
	localparam num_t NUM_HI = num_t'(NUM_MAX);
	localparam num_t NUM_LO = num_t'(NUM_MIN);
	localparam den_t DEN_HI = den_t'(DEN_MAX);

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   fail_count;
	int   pending_count;
	int   op_beats[8];
	int   zero_divisors;
	int   zero_dens;

	rau_in_if  #(.W(W)) request_if ();
	rau_out_if #(.W(W)) response_if ();

	rational_arithmetic_unit #(
		.OPERAND_WIDTH(W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_if),
		.response (response_if)
	);

	rau_fraction_checker #(
		.W(W)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.request       (request_if),
		.response      (response_if),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		response_if.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic num_t random_num();
		int v;
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: begin
				case ($urandom_range(4))
					0: v = NUM_MIN;
					1: v = NUM_MAX;
					2: v = 0;
					3: v = 1;
					default: v = -1;
				endcase
			end
			1, 2: v = $urandom_range(40);
			3, 4: v = $urandom_range(12, 2) * $urandom_range(NUM_MAX / 12);
			default: v = $urandom();
		endcase
		if (sel >= 1 && sel <= 4 && $urandom_range(1))
			v = -v;
		return num_t'(v);
	endfunction

	function automatic den_t random_den();
		int v;
		case ($urandom_range(19))
			0: v = 0;
			1, 2: v = $urandom_range(1) ? DEN_MAX : 1;
			3, 4, 5, 6: v = $urandom_range(60, 1);
			7, 8, 9: v = $urandom_range(12, 2) * $urandom_range(DEN_MAX / 12, 1);
			default: v = $urandom_range(DEN_MAX, 1);
		endcase
		return den_t'(v);
	endfunction

	// called at a rising edge; returns at the edge that takes the beat
	task automatic send_request(input logic [2:0] op, input num_t ln, input den_t ld,
		input num_t rn, input den_t rd);
		while ($urandom_range(99) < src_idle_pct) begin
			request_if.valid <= 1'b0;
			@(posedge clk);
		end
		request_if.valid     <= 1'b1;
		request_if.operation <= op;
		request_if.left_num  <= ln;
		request_if.left_den  <= ld;
		request_if.right_num <= rn;
		request_if.right_den <= rd;
		do @(posedge clk); while (!request_if.ready);
		op_beats[op]++;
		if (op == OP_DIV && rn == 0)
			zero_divisors++;
		if (ld == 0 || rd == 0)
			zero_dens++;
	endtask

	initial begin
		logic [2:0] op;
		num_t       ln;
		num_t       rn;
		den_t       ld;
		den_t       rd;
		int         base_n;
		int         base_d;
		int         scale;
		int         sel;
		int         phase;
		arst_n               = 1'b0;
		request_if.valid     = 1'b0;
		request_if.operation = OP_ADD;
		request_if.left_num  = '0;
		request_if.left_den  = 1;
		request_if.right_num = '0;
		request_if.right_den = 1;
		src_idle_pct         = 27;
		sink_idle_pct        = 81;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_ADD, NUM_LO, 1, NUM_LO, 1);
		send_request(OP_ADD, NUM_HI, DEN_HI, NUM_HI, DEN_HI);
		send_request(OP_ADD, 1, 2, -1, 2);
		send_request(OP_SUB, NUM_LO, DEN_HI, NUM_HI, 1);
		send_request(OP_SUB, 3, 4, 3, 4);
		send_request(OP_MUL, NUM_LO, 1, NUM_LO, 1);
		send_request(OP_MUL, NUM_HI, DEN_HI, NUM_LO, DEN_HI);
		send_request(OP_MUL, 0, 7, 5, 3);
		send_request(OP_DIV, 3, 4, 0, 5);
		send_request(OP_DIV, NUM_LO, 1, -1, DEN_HI);
		send_request(OP_DIV, 6, 4, -3, 2);
		send_request(OP_DIV, 0, 9, 0, 9);
		send_request(OP_EQ, 1, 2, 2, 4);
		send_request(OP_EQ, 1, 2, 1, 3);
		send_request(OP_EQ, NUM_LO, DEN_HI, NUM_LO, DEN_HI);
		send_request(OP_LT, -1, 2, 1, 3);
		send_request(OP_LT, NUM_HI, 1, NUM_LO, 1);
		send_request(OP_LT, 2, 6, 1, 3);
		send_request(OP_RSVD6, 5, 3, 7, 2);
		send_request(OP_RSVD7, NUM_LO, DEN_HI, NUM_HI, 1);
		// zero denominators fall outside the normal range but must still reduce or compare
		send_request(OP_ADD, 1, 0, 1, 0);
		send_request(OP_MUL, 5, 0, 3, 7);
		send_request(OP_DIV, 7, 0, 0, 3);
		send_request(OP_LT, 1, 0, -1, 0);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				1: begin
					src_idle_pct  = 81;
					sink_idle_pct = 27;
				end
				2: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
				default: ;
			endcase
			repeat (RANDOM_PER_PHASE) begin
				sel = $urandom_range(99);
				if (sel < 4)
					op = sel[0] ? OP_RSVD7 : OP_RSVD6;
				else
					op = 3'($urandom_range(OP_LT));
				ln = random_num();
				ld = random_den();
				rn = random_num();
				rd = random_den();
				// equivalent fractions hit equality, zero differences and unit quotients
				if ($urandom_range(3) == 0) begin
					base_n = int'($urandom_range(2 * (NUM_MAX / 4))) - NUM_MAX / 4;
					base_d = $urandom_range(DEN_MAX / 4, 1);
					scale  = $urandom_range(4, 1);
					ln = num_t'(base_n);
					ld = den_t'(base_d);
					rn = num_t'(base_n * scale);
					rd = den_t'(base_d * scale);
				end
				send_request(op, ln, ld, rn, rd);
			end
		end

		request_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d requests: add %0d, sub %0d, mul %0d, div %0d, eq %0d, lt %0d, reserved %0d",
			op_beats[OP_ADD] + op_beats[OP_SUB] + op_beats[OP_MUL] + op_beats[OP_DIV] +
			op_beats[OP_EQ] + op_beats[OP_LT] + op_beats[OP_RSVD6] + op_beats[OP_RSVD7],
			op_beats[OP_ADD], op_beats[OP_SUB], op_beats[OP_MUL], op_beats[OP_DIV],
			op_beats[OP_EQ], op_beats[OP_LT], op_beats[OP_RSVD6] + op_beats[OP_RSVD7]);
		$display("%0d zero divisors, %0d beats with a zero denominator, three pacing mixes",
			zero_divisors, zero_dens);
		if (fail_count == 0 && pending_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
